// ----- hdl/peak_program_meter_macros.svh -----
// Assertion macros shared by the meter's RTL files.
// Each macro samples on i_clk and is disabled while i_rst_n is low.
// Define ASSERT_OFF to compile every check away.
`ifndef PEAK_PROGRAM_METER_MACROS_SVH
`define PEAK_PROGRAM_METER_MACROS_SVH

`ifndef ASSERT_OFF
// cons must hold in the same cycle as ante
`define PPM_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("ppm assertion failed");
// cons must hold in the cycle after ante
`define PPM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("ppm assertion failed");
`else
`define PPM_ASSERT_SAME(lbl, ante, cons)
`define PPM_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ----- hdl/ppm_pkg.sv -----
`timescale 1ns / 1ps

package ppm_pkg;

    localparam int NUM_CHANNELS = 8;
    localparam int CH_W         = 3;
    localparam int CH_IDX_W     = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int SAMPLE_W     = 16;
    localparam int COEFF_W      = 16;
    localparam int LEVEL_W      = 24;
    localparam int PROD_W       = COEFF_W + LEVEL_W;
    localparam int CFG_IDX_W    = 2;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_ATTACK  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RELEASE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FLOOR   = 2'd2;

    localparam logic [COEFF_W-1:0] ATTACK_RESET  = 16'd300;
    localparam logic [COEFF_W-1:0] RELEASE_RESET = 16'd2;
    localparam logic [LEVEL_W-1:0] FLOOR_RESET   = 24'd56525;
    localparam logic [LEVEL_W-1:0] FULL_SCALE    = 24'd8388608;

    typedef struct packed {
        logic [CH_W-1:0]            channel;
        logic signed [SAMPLE_W-1:0] sample;
        logic                       block_end;
    } t_in_item;

    typedef struct packed {
        logic [CH_W-1:0]    out_channel;
        logic [LEVEL_W-1:0] peak_level;
    } t_out_item;

    typedef struct packed {
        logic [COEFF_W-1:0] attack_coeff;
        logic [COEFF_W-1:0] release_coeff;
        logic [LEVEL_W-1:0] floor_level;
    } t_cfg;

endpackage

// ----- hdl/ppm_cfg_regs.sv -----
`timescale 1ns / 1ps

module ppm_cfg_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [ppm_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [ppm_pkg::LEVEL_W-1:0]   i_cfg_data,
    output ppm_pkg::t_cfg                 o_cfg
);
    import ppm_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.attack_coeff  <= ATTACK_RESET;
            r_cfg.release_coeff <= RELEASE_RESET;
            r_cfg.floor_level   <= FLOOR_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_ATTACK:  r_cfg.attack_coeff  <= i_cfg_data[COEFF_W-1:0];
                REG_RELEASE: r_cfg.release_coeff <= i_cfg_data[COEFF_W-1:0];
                REG_FLOOR:   r_cfg.floor_level   <= i_cfg_data;
                default: ;  // unused index: drop the write
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ----- hdl/ppm_chan_core.sv -----
`timescale 1ns / 1ps

`include "peak_program_meter_macros.svh"

module ppm_chan_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_update,
    input  ppm_pkg::t_in_item i_item,
    input  ppm_pkg::t_cfg     i_cfg,
    output logic              o_has_result,
    output ppm_pkg::t_out_item o_result
);
    import ppm_pkg::*;

    logic [LEVEL_W-1:0] r_env  [NUM_CHANNELS];
    logic [LEVEL_W-1:0] r_peak [NUM_CHANNELS];

    logic [CH_IDX_W-1:0] idx;
    logic                ch_ok;
    logic [SAMPLE_W-1:0] raw;
    logic [SAMPLE_W-1:0] mag;
    logic [LEVEL_W-1:0]  level;
    logic [LEVEL_W-1:0]  env_cur;
    logic [LEVEL_W-1:0]  peak_cur;
    logic                go_release;
    logic [COEFF_W-1:0]  mul_k;
    logic [LEVEL_W-1:0]  mul_d;
    logic [PROD_W-1:0]   prod;
    logic [LEVEL_W-1:0]  step;
    logic                step_up;
    logic [LEVEL_W-1:0]  n_env;
    logic [LEVEL_W-1:0]  n_peak;

    assign idx   = i_item.channel[CH_IDX_W-1:0];
    assign ch_ok = ({1'b0, i_item.channel} < (CH_W+1)'(NUM_CHANNELS));

    // magnitude; the most negative sample maps to 32768
    assign raw   = i_item.sample;
    assign mag   = raw[SAMPLE_W-1] ? (~raw + 1'b1) : raw;
    assign level = {mag, 8'h00};

    assign env_cur  = r_env[idx];
    assign peak_cur = r_peak[idx];

    // release: e - ceil(rel*e / 2^16); attack: e + floor(att*(M-e) / 2^16)
    assign go_release = (env_cur > level);
    assign mul_k      = go_release ? i_cfg.release_coeff : i_cfg.attack_coeff;
    assign mul_d      = go_release ? env_cur : (level - env_cur);
    assign prod       = PROD_W'(mul_k) * PROD_W'(mul_d);
    assign step       = prod[PROD_W-1:COEFF_W];
    assign step_up    = |prod[COEFF_W-1:0];
    assign n_env      = go_release ? (env_cur - step - LEVEL_W'(step_up))
                                   : (env_cur + step);
    assign n_peak     = (n_env > peak_cur) ? n_env : peak_cur;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < NUM_CHANNELS; c++) begin
                r_env[c]  <= '0;
                r_peak[c] <= '0;
            end
        end else if (i_update && ch_ok) begin
            r_env[idx]  <= n_env;
            r_peak[idx] <= i_item.block_end ? '0 : n_peak;
        end
    end

    assign o_has_result         = ch_ok && i_item.block_end;
    assign o_result.out_channel = i_item.channel;
    assign o_result.peak_level  = (n_peak < i_cfg.floor_level) ? i_cfg.floor_level : n_peak;

    `PPM_ASSERT_SAME(a_env_bounded, i_update && ch_ok, n_env <= FULL_SCALE)

endmodule

// ----- hdl/peak_program_meter.sv -----
`timescale 1ns / 1ps

`include "peak_program_meter_macros.svh"

// Multichannel peak program meter with attack/release envelope.
// Input channel: one request per sample (channel, signed sample, block_end), moved
// at a rising edge with i_in_valid high and o_in_stall low.
// Output channel: one request per block end carrying the channel and its block peak,
// floored at floor_level; taken at an edge with o_out_valid high and i_out_stall low.
// Configuration: i_cfg_we writes i_cfg_data to register i_cfg_index
// (0 attack_coeff, 1 release_coeff, 2 floor_level); other indexes are dropped.
// The input register holds a taken request; when it advances, it updates its channel
// and, on block_end, loads the output register that drives o_out_valid.
// Throughput: one sample per cycle unless a block_end sample waits for the output
// register; the rate is set by the single 16x24 multiplier between the input register
// and the channel state; state is written back in the same cycle, so consecutive samples of one channel need no bypass.
// Reset (synchronous, active low) clears all envelopes and block peaks, loads the
// default coefficients and empties both request registers.
// While the receiver stalls, the held result stays put; samples without block_end
// keep flowing, and a block_end sample waits in the input register, which raises
// o_in_stall until the output register frees up.
module peak_program_meter (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  ppm_pkg::t_in_item             i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output ppm_pkg::t_out_item            o_out_data,
    input  logic                          i_cfg_we,
    input  logic [ppm_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [ppm_pkg::LEVEL_W-1:0]   i_cfg_data
);
    import ppm_pkg::*;

    t_cfg      cfg;
    t_in_item  r_in;
    logic      r_in_valid;
    logic      n_in_valid;
    t_out_item r_out;
    logic      r_out_valid;
    logic      n_out_valid;
    logic      in_take;
    logic      out_free;
    logic      advance;
    logic      has_result;
    t_out_item result;

    ppm_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    ppm_chan_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_update     (advance),
        .i_item       (r_in),
        .i_cfg        (cfg),
        .o_has_result (has_result),
        .o_result     (result)
    );

    // Output slot is free when empty or being taken this cycle.
    assign out_free = !r_out_valid || !i_out_stall;
    // Advance the held request unless it needs the output slot and the slot is busy.
    assign advance  = r_in_valid && (!r_in.block_end || out_free);

    assign o_in_stall = r_in_valid && !advance;
    assign in_take    = i_in_valid && !o_in_stall;
    assign n_in_valid = in_take || (r_in_valid && !advance);

    always_comb begin
        n_out_valid = r_out_valid && i_out_stall;
        if (advance && has_result) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers: load only on a move, hold otherwise.
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in <= i_in_data;
        end
        if (advance && has_result) begin
            r_out <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    `PPM_ASSERT_SAME(a_stall_needs_item, o_in_stall, r_in_valid)
    `PPM_ASSERT_SAME(a_block_end_waits,
                     r_in_valid && r_in.block_end && r_out_valid && i_out_stall, o_in_stall)
    `PPM_ASSERT_SAME(a_result_from_advance, $rose(o_out_valid),
                     $past(r_in_valid) && $past(r_in.block_end))
    `PPM_ASSERT_NEXT(a_result_not_lost, r_out_valid && i_out_stall, r_out_valid)

endmodule
